FILE: rtl/ubdc_pkg.sv
// ----------------------------------------------------------------------------
// ubdc_pkg
// Shared widths, constants and types of the UART baud divisor calculator.
// ----------------------------------------------------------------------------
package ubdc_pkg;

   // Port field widths
   localparam int CLK_W    = 27;
   localparam int BAUD_W   = 24;
   localparam int WORD_W   = 16;
   localparam int STATUS_W = 2;

   // Internal datapath widths
   localparam int NUM_W    = 32;          // 25 * clock
   localparam int DEN_W    = BAUD_W + 2;  // 4 * baud
   localparam int QUO_W    = NUM_W;       // divider quotient
   localparam int STEP_W   = $clog2(QUO_W);
   localparam int MANT_W   = 12;
   localparam int FRAC_W   = 4;
   localparam int DIV_LO_W = 19;          // holds any scaled divisor below the limit
   localparam int REM_W    = 7;           // remainder of a division by 100

   // Arithmetic constants
   localparam int CLK_SCALE    = 25;
   localparam int MANT_MAX     = 4095;
   localparam int SAT_LIMIT    = (MANT_MAX + 1) * 100;
   localparam int ROUND_BIAS   = 50;
   // floor(x / 100) = (x * RECIP100) >> RECIP_SHIFT, exact for x < SAT_LIMIT
   localparam int RECIP100     = 671089;
   localparam int RECIP_SHIFT  = 26;
   localparam int RECIP_W      = 20;
   localparam int SCALE_PROD_W = DIV_LO_W + RECIP_W;
   // floor(y / 100) for the small rounding operand y < 2048
   localparam int FRAC_RECIP   = 2622;
   localparam int FRAC_SHIFT   = 18;
   localparam int FRAC_IN_W    = 11;
   localparam int FRAC_RECIP_W = 12;
   localparam int FRAC_PROD_W  = FRAC_IN_W + FRAC_RECIP_W;
   localparam int FRAC_FULL_W  = 5;

   localparam logic [FRAC_W-1:0] FRAC_MASK_16 = 4'hF;
   localparam logic [FRAC_W-1:0] FRAC_MASK_8  = 4'h7;

   // Request queue depth between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAUD_ZERO = 2'd1,
      STATUS_SAT       = 2'd2
   } status_type;

   // One classified request waiting for the divider
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             by8;
      logic             baud_zero;
   } job_type;

endpackage

FILE: rtl/ubdc_front.sv
// ----------------------------------------------------------------------------
// ubdc_front
// Classifies a request: scales the clock, forms the divisor and flags a
// zero baud rate, then hands the job to the queue.
// ----------------------------------------------------------------------------
module ubdc_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ubdc_pkg::CLK_W-1:0]  req_bus_clock_hz,
   input  logic [ubdc_pkg::BAUD_W-1:0] req_baud_rate,
   input  logic                       req_oversample_by_8,
   output logic                       push_valid,
   input  logic                       push_ready,
   output ubdc_pkg::job_type          push_data
);

   // Scale the clock by 25 and the baud rate by 2 or 4
   always_comb begin
      push_data.num       = ubdc_pkg::NUM_W'(req_bus_clock_hz) *
                            ubdc_pkg::NUM_W'(ubdc_pkg::CLK_SCALE);
      push_data.den       = req_oversample_by_8 ?
                            ubdc_pkg::DEN_W'({req_baud_rate, 1'b0}) :
                            ubdc_pkg::DEN_W'({req_baud_rate, 2'b00});
      push_data.by8       = req_oversample_by_8;
      push_data.baud_zero = (req_baud_rate == '0);
   end

   // Transfer straight into the queue
   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

FILE: rtl/ubdc_queue.sv
// ----------------------------------------------------------------------------
// ubdc_queue
// Small register FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
module ubdc_queue #(
   parameter int DEPTH = ubdc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ubdc_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ubdc_pkg::job_type pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ubdc_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/ubdc_back.sv
// ----------------------------------------------------------------------------
// ubdc_back
// Runs one job: restoring division one quotient bit per cycle, split into
// mantissa and remainder by 100, rounds the fraction and packs the word.
// ----------------------------------------------------------------------------
module ubdc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  ubdc_pkg::job_type            pop_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ubdc_pkg::WORD_W-1:0]   rsp_divisor_word,
   output logic [ubdc_pkg::STATUS_W-1:0] rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCALE,
      ST_REMAIN,
      ST_PACK
   } state_type;

   state_type                           state_ff, state_in;
   logic [ubdc_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [ubdc_pkg::QUO_W-1:0]          nq_ff, nq_in;
   logic [ubdc_pkg::DEN_W-1:0]          den_ff, den_in;
   logic [ubdc_pkg::DEN_W-1:0]          part_ff, part_in;
   logic                                by8_ff, by8_in;
   logic                                zero_ff, zero_in;
   logic                                sat_ff, sat_in;
   logic [ubdc_pkg::MANT_W-1:0]         mant_ff, mant_in;
   logic [ubdc_pkg::DIV_LO_W-1:0]       div_lo_ff, div_lo_in;
   logic [ubdc_pkg::REM_W-1:0]          rem_ff, rem_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ubdc_pkg::WORD_W-1:0]         word_ff, word_in;
   logic [ubdc_pkg::STATUS_W-1:0]       status_ff, status_in;

   logic [ubdc_pkg::DEN_W:0]            trial;
   logic                                q_bit;
   logic [ubdc_pkg::SCALE_PROD_W-1:0]   scale_prod;
   logic [ubdc_pkg::DIV_LO_W-1:0]       mant_x100;
   logic [ubdc_pkg::DIV_LO_W-1:0]       rem_wide;
   logic [ubdc_pkg::FRAC_IN_W-1:0]      frac_op;
   logic [ubdc_pkg::FRAC_PROD_W-1:0]    frac_prod;
   logic [ubdc_pkg::FRAC_FULL_W-1:0]    frac_full;
   logic [ubdc_pkg::FRAC_W-1:0]         frac_mask;

   assign pop_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_divisor_word = word_ff;
   assign rsp_status       = status_ff;

   // One restoring division step
   always_comb begin
      trial = {part_ff, nq_ff[ubdc_pkg::QUO_W-1]};
      q_bit = (trial >= {1'b0, den_ff});
   end

   // Mantissa by reciprocal of 100, remainder, rounded fraction
   always_comb begin
      scale_prod = ubdc_pkg::SCALE_PROD_W'(nq_ff[ubdc_pkg::DIV_LO_W-1:0]) *
                   ubdc_pkg::SCALE_PROD_W'(ubdc_pkg::RECIP100);
      mant_x100  = ubdc_pkg::DIV_LO_W'({mant_ff, 6'b0}) +
                   ubdc_pkg::DIV_LO_W'({mant_ff, 5'b0}) +
                   ubdc_pkg::DIV_LO_W'({mant_ff, 2'b0});
      rem_wide   = div_lo_ff - mant_x100;
      frac_op    = (by8_ff ? ubdc_pkg::FRAC_IN_W'({rem_ff, 3'b0}) :
                             ubdc_pkg::FRAC_IN_W'({rem_ff, 4'b0})) +
                   ubdc_pkg::FRAC_IN_W'(ubdc_pkg::ROUND_BIAS);
      frac_prod  = ubdc_pkg::FRAC_PROD_W'(frac_op) *
                   ubdc_pkg::FRAC_PROD_W'(ubdc_pkg::FRAC_RECIP);
      frac_full  = frac_prod[ubdc_pkg::FRAC_SHIFT +: ubdc_pkg::FRAC_FULL_W];
      frac_mask  = by8_ff ? ubdc_pkg::FRAC_MASK_8 : ubdc_pkg::FRAC_MASK_16;
   end

   // Sequence one job and hold the result until transferred
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      nq_in        = nq_ff;
      den_in       = den_ff;
      part_in      = part_ff;
      by8_in       = by8_ff;
      zero_in      = zero_ff;
      sat_in       = sat_ff;
      mant_in      = mant_ff;
      div_lo_in    = div_lo_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      word_in      = word_ff;
      status_in    = status_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               nq_in    = pop_data.num;
               den_in   = pop_data.den;
               by8_in   = pop_data.by8;
               zero_in  = pop_data.baud_zero;
               part_in  = '0;
               step_in  = '0;
               state_in = pop_data.baud_zero ? ST_PACK : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            part_in = q_bit ? ubdc_pkg::DEN_W'(trial - {1'b0, den_ff}) :
                              trial[ubdc_pkg::DEN_W-1:0];
            nq_in   = {nq_ff[ubdc_pkg::QUO_W-2:0], q_bit};
            step_in = step_ff + 1'b1;
            if (step_ff == ubdc_pkg::STEP_W'(ubdc_pkg::QUO_W - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            sat_in    = (nq_ff >= ubdc_pkg::QUO_W'(ubdc_pkg::SAT_LIMIT));
            mant_in   = scale_prod[ubdc_pkg::RECIP_SHIFT +: ubdc_pkg::MANT_W];
            div_lo_in = nq_ff[ubdc_pkg::DIV_LO_W-1:0];
            state_in  = ST_REMAIN;
         end
         ST_REMAIN: begin
            rem_in   = rem_wide[ubdc_pkg::REM_W-1:0];
            state_in = ST_PACK;
         end
         ST_PACK: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  word_in   = '0;
                  status_in = ubdc_pkg::STATUS_BAUD_ZERO;
               end else if (sat_ff) begin
                  word_in   = {ubdc_pkg::MANT_W'(ubdc_pkg::MANT_MAX), frac_mask};
                  status_in = ubdc_pkg::STATUS_SAT;
               end else begin
                  word_in   = {mant_ff, frac_full[ubdc_pkg::FRAC_W-1:0] & frac_mask};
                  status_in = ubdc_pkg::STATUS_OK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nq_ff     <= nq_in;
      den_ff    <= den_in;
      part_ff   <= part_in;
      by8_ff    <= by8_in;
      zero_ff   <= zero_in;
      sat_ff    <= sat_in;
      mant_ff   <= mant_in;
      div_lo_ff <= div_lo_in;
      rem_ff    <= rem_in;
      word_ff   <= word_in;
      status_ff <= status_in;
   end

endmodule

FILE: rtl/uart_baud_divisor_calc_top.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_top
// Computes the packed fractional UART baud register word from a bus clock,
// a baud rate and the oversampling choice.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | bus_clock_hz, baud_rate,
//           |           |                       | oversample_by_8
//   rsp     | out       | rsp_valid / rsp_ready | divisor_word, status
//
// In the back end a request is loaded, then the restoring divider yields one
// quotient bit per cycle, then the quotient is scaled, the remainder taken and
// the word packed. A zero baud rate is loaded and goes straight to packing.
// The front queue accepts new requests while the divider runs; the result
// register holds a finished word while the next request is divided.
// Synchronous reset empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_top #(
   parameter int QUEUE_DEPTH = ubdc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ubdc_pkg::CLK_W-1:0]    req_bus_clock_hz,
   input  logic [ubdc_pkg::BAUD_W-1:0]   req_baud_rate,
   input  logic                         req_oversample_by_8,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ubdc_pkg::WORD_W-1:0]   rsp_divisor_word,
   output logic [ubdc_pkg::STATUS_W-1:0] rsp_status
);

   logic              push_valid, push_ready;
   ubdc_pkg::job_type push_data;
   logic              pop_valid, pop_ready;
   ubdc_pkg::job_type pop_data;

   // Classify requests
   ubdc_front u_front (
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_bus_clock_hz    (req_bus_clock_hz),
      .req_baud_rate       (req_baud_rate),
      .req_oversample_by_8 (req_oversample_by_8),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_data           (push_data)
   );

   // Buffer jobs between front and back
   ubdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Divide and pack
   ubdc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_divisor_word (rsp_divisor_word),
      .rsp_status       (rsp_status)
   );

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UART baud divisor calculator. A directed table
// covers zero baud, zero clock, saturation edges and rounding carries; random
// requests follow in phases with different sender and receiver idling. Each
// response is checked against its typed word or a local divisor predictor.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CENTI          = 100;     // divisor is scaled by 100
   localparam int RESET_CYCLES   = 6;
   localparam int ITEMS_PER_PASS = 490;
   localparam int LONG_HOLD      = 500;     // receiver hold-off that backs up the queue
   localparam int STALL_LIMIT    = 4000;    // cycles without any transfer
   localparam int TAIL_CYCLES    = 80;
   localparam int REPORT_MAX     = 10;

   typedef struct packed {
      logic [ubdc_pkg::WORD_W-1:0] word;
      ubdc_pkg::status_type        status;
   } baud_word_type;

   typedef struct packed {
      logic [ubdc_pkg::CLK_W-1:0]  clk_hz;
      logic [ubdc_pkg::BAUD_W-1:0] baud;
      logic                        by8;
      logic                        fixed;     // expected result typed in the row
      logic [ubdc_pkg::WORD_W-1:0] word;
      ubdc_pkg::status_type        status;
   } stim_row_type;

   localparam int ROW_COUNT = 21;
   localparam stim_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{27'd100000000, 24'd0,        1'b0, 1'b1, 16'h0000, ubdc_pkg::STATUS_BAUD_ZERO},
      '{27'h7FFFFFF,   24'd0,        1'b1, 1'b1, 16'h0000, ubdc_pkg::STATUS_BAUD_ZERO},
      '{27'd0,         24'd9600,     1'b0, 1'b1, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'd0,         24'hFFFFFF,   1'b1, 1'b1, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'h7FFFFFF,   24'd1,        1'b0, 1'b1, 16'hFFFF, ubdc_pkg::STATUS_SAT},
      '{27'h7FFFFFF,   24'd1,        1'b1, 1'b1, 16'hFFF7, ubdc_pkg::STATUS_SAT},
      '{27'd65520,     24'd1,        1'b0, 1'b1, 16'hFFF0, ubdc_pkg::STATUS_OK},
      '{27'd65536,     24'd1,        1'b0, 1'b1, 16'hFFFF, ubdc_pkg::STATUS_SAT},
      '{27'd32760,     24'd1,        1'b1, 1'b1, 16'hFFF0, ubdc_pkg::STATUS_OK},
      '{27'd32768,     24'd1,        1'b1, 1'b1, 16'hFFF7, ubdc_pkg::STATUS_SAT},
      '{27'd1,         24'hFFFFFF,   1'b0, 1'b1, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'd65535,     24'd1,        1'b0, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'd47,        24'd3,        1'b0, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'd23,        24'd3,        1'b1, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'h7FFFFFF,   24'hFFFFFF,   1'b0, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'd16000000,  24'd9600,     1'b0, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'd84000000,  24'd115200,   1'b1, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'd42000000,  24'd16000000, 1'b0, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'd100000000, 24'h800000,   1'b1, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'h4000000,   24'h555555,   1'b0, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK},
      '{27'h2AAAAAA,   24'hAAAAAA,   1'b1, 1'b0, 16'h0000, ubdc_pkg::STATUS_OK}
   };

   // Idling per pass: none, sender only, receiver only, both
   localparam int SEND_IDLE [4] = '{0, 60, 0, 34};
   localparam int RECV_IDLE [4] = '{0, 0, 60, 34};

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [ubdc_pkg::CLK_W-1:0]    req_bus_clock_hz = '0;
   logic [ubdc_pkg::BAUD_W-1:0]   req_baud_rate = '0;
   logic                          req_oversample_by_8 = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [ubdc_pkg::WORD_W-1:0]   rsp_divisor_word;
   logic [ubdc_pkg::STATUS_W-1:0] rsp_status;

   baud_word_type expected_words [$];
   int            mismatches = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   bit            hold_request = 1'b0;

   uart_baud_divisor_calc_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_bus_clock_hz    (req_bus_clock_hz),
      .req_baud_rate       (req_baud_rate),
      .req_oversample_by_8 (req_oversample_by_8),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_divisor_word    (rsp_divisor_word),
      .rsp_status          (rsp_status)
   );

   always #1 clock = ~clock;

   // Predict the packed baud register word and status for one request
   function automatic baud_word_type calc_baud_word(logic [ubdc_pkg::CLK_W-1:0] clk_hz,
                                                    logic [ubdc_pkg::BAUD_W-1:0] baud,
                                                    logic by8);
      logic [63:0]   scaled_div;
      logic [63:0]   mant;
      logic [63:0]   rem;
      logic [63:0]   frac;
      baud_word_type res;
      res.word   = '0;
      res.status = ubdc_pkg::STATUS_BAUD_ZERO;
      if (baud == '0) begin
         return res;
      end
      scaled_div = (64'(clk_hz) * ubdc_pkg::CLK_SCALE) / (64'(baud) * (by8 ? 2 : 4));
      mant       = scaled_div / CENTI;
      rem        = scaled_div - mant * CENTI;
      // round the remainder, then mask: a carry out is lost
      if (by8) begin
         frac = ((rem * 8 + ubdc_pkg::ROUND_BIAS) / CENTI) & 64'(ubdc_pkg::FRAC_MASK_8);
      end else begin
         frac = ((rem * 16 + ubdc_pkg::ROUND_BIAS) / CENTI) & 64'(ubdc_pkg::FRAC_MASK_16);
      end
      if (mant > ubdc_pkg::MANT_MAX) begin
         res.word   = {ubdc_pkg::MANT_W'(ubdc_pkg::MANT_MAX),
                       by8 ? ubdc_pkg::FRAC_MASK_8 : ubdc_pkg::FRAC_MASK_16};
         res.status = ubdc_pkg::STATUS_SAT;
      end else begin
         res.word   = {mant[ubdc_pkg::MANT_W-1:0], frac[ubdc_pkg::FRAC_W-1:0]};
         res.status = ubdc_pkg::STATUS_OK;
      end
      return res;
   endfunction

   // Offer one request, wait for its transfer and queue the expected word
   task automatic offer_request(stim_row_type row);
      baud_word_type exp_word;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid           <= 1'b1;
      req_bus_clock_hz    <= row.clk_hz;
      req_baud_rate       <= row.baud;
      req_oversample_by_8 <= row.by8;
      do @(posedge clock); while (!req_ready);
      if (row.fixed) begin
         exp_word.word   = row.word;
         exp_word.status = row.status;
      end else begin
         exp_word = calc_baud_word(row.clk_hz, row.baud, row.by8);
      end
      expected_words.push_back(exp_word);
   endtask

   // Draw a random request, mostly with a mantissa inside the register range
   function automatic stim_row_type pick_request();
      stim_row_type row;
      logic [31:0]  bits;
      int           kind;
      int           mant_goal;
      int           over;
      row        = '0;
      row.status = ubdc_pkg::STATUS_OK;
      kind       = $urandom_range(99);
      bits       = $urandom;
      row.by8    = bits[31];
      if (kind < 5) begin
         // zero baud rate with any clock
         row.clk_hz = bits[ubdc_pkg::CLK_W-1:0];
      end else if (kind < 17) begin
         // raw bit patterns over the full field widths
         row.clk_hz = bits[ubdc_pkg::CLK_W-1:0];
         bits       = $urandom;
         row.baud   = bits[ubdc_pkg::BAUD_W-1:0];
      end else if (kind < 27) begin
         // slow baud rates that push the mantissa toward saturation
         row.clk_hz = ubdc_pkg::CLK_W'($urandom_range(1, 100000000));
         row.baud   = ubdc_pkg::BAUD_W'($urandom_range(1, 2000));
      end else if (kind < 32) begin
         // tiny clocks and baud rates exercise the fraction rounding
         row.clk_hz = ubdc_pkg::CLK_W'($urandom_range(0, 1000));
         row.baud   = ubdc_pkg::BAUD_W'($urandom_range(1, 50));
      end else begin
         // realistic set-up aimed at a chosen mantissa
         over      = row.by8 ? 8 : 16;
         mant_goal = ($urandom_range(9) == 0) ? $urandom_range(4090, 4096)
                                              : $urandom_range(1, 4095);
         row.clk_hz = ubdc_pkg::CLK_W'($urandom_range(1, 100000000));
         row.baud   = ubdc_pkg::BAUD_W'(row.clk_hz / (over * mant_goal) +
                                        $urandom_range(0, 3));
         if (row.baud == '0) begin
            row.baud = ubdc_pkg::BAUD_W'(1);
         end
      end
      return row;
   endfunction

   // Check every response transfer and drive the receiver's ready
   initial begin : recv_proc
      baud_word_type exp_word;
      int            hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("unexpected response: word %h status %0d",
                           rsp_divisor_word, rsp_status);
               end
            end else begin
               exp_word = expected_words.pop_front();
               if (rsp_divisor_word !== exp_word.word ||
                   rsp_status !== ubdc_pkg::STATUS_W'(exp_word.status)) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("mismatch: word exp %h got %h, status exp %0d got %0d",
                              exp_word.word, rsp_divisor_word,
                              exp_word.status, rsp_status);
                  end
               end
            end
         end
         // hold off for a long stretch when asked, else stall at random
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // End the run when no transfer happens for too long
   initial begin : watchdog_proc
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Reset, directed table, then random passes with varying idling
   initial begin : stim_proc
      int pass;
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < ROW_COUNT; n++) begin
         offer_request(DIRECTED_ROWS[n]);
      end

      for (pass = 0; pass < 4; pass++) begin
         send_idle_pct  = SEND_IDLE[pass];
         recv_stall_pct = RECV_IDLE[pass];
         // back up the block early in the first pass
         if (pass == 0) begin
            hold_request = 1'b1;
         end
         for (n = 0; n < ITEMS_PER_PASS; n++) begin
            offer_request(pick_request());
         end
         // pause the sender until every response has come back
         req_valid <= 1'b0;
         while (expected_words.size() != 0) @(posedge clock);
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: uart_baud_divisor_calc_top.f
rtl/ubdc_pkg.sv
rtl/ubdc_front.sv
rtl/ubdc_queue.sv
rtl/ubdc_back.sv
rtl/uart_baud_divisor_calc_top.sv
sim/testbench.sv
